### hdl/edts_pkg.sv
// ----------------------------------------------------------------------------
// edts_pkg
// Shared widths, constants, types and elaboration-time functions for the
// exponential default time sampler.
// ----------------------------------------------------------------------------
package edts_pkg;

    localparam int UNIFORM_BITS_DEF = 32;

    localparam int SAMPLE_W   = 32;
    localparam int HAZARD_W   = 32;
    localparam int HORIZON_W  = 31;
    localparam int TIME_W     = 32;
    localparam int CFG_DATA_W = 32;

    // Log sum in Q58, mantissa in Q61 with room for the value 2.0.
    localparam int L_W        = 64;
    localparam int X_W        = 63;
    localparam int LOG_STAGES = 24;

    localparam int HAZARD_SHIFT = 18;
    localparam int D_W          = HAZARD_W + HAZARD_SHIFT;
    localparam int N_W          = L_W + 1;
    localparam int QUOT_BITS    = 31;
    localparam int CMP_W        = D_W + QUOT_BITS;

    localparam logic [L_W-1:0]    LN2_Q58  = 64'hB17217F7D1CF79AB >> 6;
    localparam logic [X_W-1:0]    TWO_X    = 63'h1 << 62;
    localparam logic [TIME_W-1:0] ONE_Q16  = 32'd65536;

    typedef enum logic [0:0] {
        REG_HAZARD  = 1'b0,
        REG_HORIZON = 1'b1
    } reg_index_t;

    // Valid bit and a per-item flag travelling along the pipeline.
    typedef struct packed {
        logic valid;
        logic flag;
    } stage_ctl_t;

    // ln(1 + 2^-i) in Q58, from the alternating series worked out in Q62.
    function automatic logic [L_W-1:0] ln_factor_q58(input int i);
        logic [L_W-1:0] acc;
        logic [L_W-1:0] term;
        int             k;
        acc = '0;
        for (k = 1; k <= 62; k++)
        begin
            if (i * k <= 62)
            begin
                term = (64'h1 << 62) >> (i * k);
                term = term / 64'(k);
                if ((k % 2) == 1)
                begin
                    acc = acc + term;
                end
                else
                begin
                    acc = acc - term;
                end
            end
        end
        return acc >> 4;
    endfunction

endpackage

### hdl/edts_draw_if.sv
// ----------------------------------------------------------------------------
// edts_draw_if
// Channel carrying one uniform draw per word.
// ----------------------------------------------------------------------------
interface edts_draw_if
    import edts_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] uniform_sample;

    modport source (output valid, output uniform_sample, input ready);
    modport sink   (input valid, input uniform_sample, output ready);
endinterface

### hdl/edts_sample_if.sv
// ----------------------------------------------------------------------------
// edts_sample_if
// Channel carrying one sampled default time per word.
// ----------------------------------------------------------------------------
interface edts_sample_if
    import edts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] default_time;
    logic              no_default;

    modport source (output valid, output default_time, output no_default, input ready);
    modport sink   (input valid, input default_time, input no_default, output ready);
endinterface

### hdl/exponential_default_time_sampler_core.sv
// ----------------------------------------------------------------------------
// exponential_default_time_sampler_core: inverse transform default time.
// Pipeline: 61 register stages lie between an accepted draw and its result.
// Throughput: one word per cycle while the output is not held, set by the fully pipelined log and divider.
// Reset: rst_n clears all valid bits, hazard_rate to 0 and time_horizon to 1.0.
// ----------------------------------------------------------------------------
//
// The draw goes through three parts. The normaliser finds the leading one of
// the draw in two shift stages and forms (k - 1) * ln2 in a third. The log
// unit brings the mantissa towards 2 with one factor (1 + 2^-i) per stage and
// adds the matching ln constants; the small remainder is folded in linearly.
// The divider adds half the divisor for rounding, checks that the quotient
// fits 31 bits and then produces one quotient bit per stage. A final output
// register compares against the horizon and forms the sentinel.
//
// All stages share one advance enable: the pipeline moves whenever the output
// register is empty or its word is being taken, so a stall freezes every
// stage and nothing is dropped or repeated. The configuration registers are
// read live by the divider and the output stage; the user must change them only
// while the pipeline is empty, as the block itself does not enforce it.
module exponential_default_time_sampler_core
    import edts_pkg::*;
#(
    parameter int UNIFORM_BITS = UNIFORM_BITS_DEF,
    parameter int STAGES       = LOG_STAGES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  reg_index_t            wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    edts_draw_if.sink             draw,
    edts_sample_if.source         sample
);

    logic [HAZARD_W-1:0]  hazard_reg;
    logic [HORIZON_W-1:0] horizon_reg;

    logic                 en;

    stage_ctl_t           norm_ctl;
    logic [X_W-1:0]       norm_x;
    logic [L_W-1:0]       norm_base;
    stage_ctl_t           log_ctl;
    logic [L_W-1:0]       log_sum;
    stage_ctl_t           div_ctl;
    logic [QUOT_BITS-1:0] div_quot;

    logic [TIME_W-1:0]    sentinel;
    logic                 none_next;

    logic                 out_valid_reg;
    logic [TIME_W-1:0]    out_time_reg;
    logic                 out_none_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hazard_reg  <= '0;
            horizon_reg <= HORIZON_W'(ONE_Q16);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_HAZARD:  hazard_reg  <= wr_data[HAZARD_W-1:0];
                REG_HORIZON: horizon_reg <= wr_data[HORIZON_W-1:0];
                default:     ;
            endcase
        end
    end

    // The whole pipeline advances together unless a finished word is held.
    assign en         = !out_valid_reg || sample.ready;
    assign draw.ready = en;

    edts_norm #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_norm (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (draw.valid),
        .sample_word (draw.uniform_sample),
        .ctl         (norm_ctl),
        .x           (norm_x),
        .base        (norm_base)
    );

    edts_log #(
        .STAGES (STAGES)
    ) u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_ctl (norm_ctl),
        .in_x   (norm_x),
        .in_l   (norm_base),
        .ctl    (log_ctl),
        .l_sum  (log_sum)
    );

    edts_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_ctl (log_ctl),
        .in_l   (log_sum),
        .hazard (hazard_reg),
        .ctl    (div_ctl),
        .quot   (div_quot)
    );

    // A time beyond the horizon, a zero draw or a zero rate gives the sentinel.
    assign sentinel  = {1'b0, horizon_reg} + ONE_Q16;
    assign none_next = div_ctl.flag || (div_quot > horizon_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_time_reg <= none_next ? sentinel : {1'b0, div_quot};
            out_none_reg <= none_next;
        end
    end

    assign sample.valid        = out_valid_reg;
    assign sample.default_time = out_time_reg;
    assign sample.no_default   = out_none_reg;

`ifndef NO_ASSERTIONS
    // A flagged word always carries the sentinel.
    a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.no_default |-> sample.default_time == sentinel)
        else $error("no_default word without sentinel time");

    // An unflagged time never lies beyond the horizon.
    a_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && !sample.no_default |-> sample.default_time <= {1'b0, horizon_reg})
        else $error("default time beyond horizon");

    // A zero hazard rate never yields a default.
    a_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && (hazard_reg == '0) |-> sample.no_default)
        else $error("default reported with zero hazard rate");
`endif

endmodule

### hdl/edts_norm.sv
// ----------------------------------------------------------------------------
// edts_norm
// Three-stage normaliser: leading-zero shift of the draw, exponent term
// (k - 1) * ln2 and the mantissa in Q61.
// ----------------------------------------------------------------------------
module edts_norm
    import edts_pkg::*;
#(
    parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [SAMPLE_W-1:0] sample_word,
    output stage_ctl_t          ctl,
    output logic [X_W-1:0]      x,
    output logic [L_W-1:0]      base
);

    localparam int KM_W = $clog2(UNIFORM_BITS);
    localparam int OFFS = UNIFORM_BITS - SAMPLE_W;
    localparam logic [SAMPLE_W:0] MASK_W = (UNIFORM_BITS >= SAMPLE_W) ?
        {1'b0, {SAMPLE_W{1'b1}}} : ((33'd1 << UNIFORM_BITS) - 33'd1);

    stage_ctl_t           ctl1_reg, ctl2_reg, ctl3_reg;
    logic [SAMPLE_W-1:0]  w1_reg, w2_reg;
    logic [1:0]           s1_reg;
    logic [KM_W-1:0]      km2_reg;
    logic [X_W-1:0]       x3_reg;
    logic [L_W-1:0]       base3_reg;

    logic [SAMPLE_W-1:0]  code;
    logic [SAMPLE_W-1:0]  a1, a2;
    logic [1:0]           s1;
    logic [2:0]           s2;
    logic [7:0]           km_wide;
    logic [L_W-1:0]       base_next;

    // Coarse shift by 16 and 8.
    always_comb
    begin
        code = sample_word & MASK_W[SAMPLE_W-1:0];
        a1   = code;
        s1   = 2'b00;
        if (a1[31:16] == 16'd0)
        begin
            a1    = {a1[15:0], 16'd0};
            s1[1] = 1'b1;
        end
        if (a1[31:24] == 8'd0)
        begin
            a1    = {a1[23:0], 8'd0};
            s1[0] = 1'b1;
        end
    end

    // Fine shift by 4, 2 and 1.
    always_comb
    begin
        a2 = w1_reg;
        s2 = 3'b000;
        if (a2[31:28] == 4'd0)
        begin
            a2    = {a2[27:0], 4'd0};
            s2[2] = 1'b1;
        end
        if (a2[31:30] == 2'd0)
        begin
            a2    = {a2[29:0], 2'd0};
            s2[1] = 1'b1;
        end
        if (a2[31] == 1'b0)
        begin
            a2    = {a2[30:0], 1'b0};
            s2[0] = 1'b1;
        end
        km_wide = 8'(OFFS) + {3'b000, s1_reg, s2};
    end

    // (k - 1) * ln2 as a short shift-add over the bits of k - 1.
    always_comb
    begin
        base_next = '0;
        for (int b = 0; b < KM_W; b++)
        begin
            if (km2_reg[b])
            begin
                base_next = base_next + (LN2_Q58 << b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= '{valid: in_valid, flag: (code == '0)};
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg    <= a1;
            s1_reg    <= s1;
            w2_reg    <= a2;
            km2_reg   <= km_wide[KM_W-1:0];
            x3_reg    <= {1'b0, w2_reg, 30'd0};
            base3_reg <= base_next;
        end
    end

    assign ctl  = ctl3_reg;
    assign x    = x3_reg;
    assign base = base3_reg;

endmodule

### hdl/edts_log.sv
// ----------------------------------------------------------------------------
// edts_log
// Multiplicative normalisation of the mantissa towards 2, one factor
// (1 + 2^-i) per stage, followed by a linear correction for the remainder.
// ----------------------------------------------------------------------------
module edts_log
    import edts_pkg::*;
#(
    parameter int STAGES = LOG_STAGES
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  stage_ctl_t     in_ctl,
    input  logic [X_W-1:0] in_x,
    input  logic [L_W-1:0] in_l,
    output stage_ctl_t     ctl,
    output logic [L_W-1:0] l_sum
);

    stage_ctl_t     ctl_w [STAGES+1];
    logic [X_W-1:0] x_w   [STAGES+1];
    logic [L_W-1:0] l_w   [STAGES+1];

    stage_ctl_t     fin_ctl_reg;
    logic [L_W-1:0] fin_l_reg;
    logic [X_W-1:0] resid;

    assign ctl_w[0] = in_ctl;
    assign x_w[0]   = in_x;
    assign l_w[0]   = in_l;

    for (genvar i = 1; i <= STAGES; i++)
    begin : g_stage
        localparam logic [L_W-1:0] LNF = ln_factor_q58(i);
        stage_ctl_t     ctl_reg;
        logic [X_W-1:0] x_reg;
        logic [L_W-1:0] l_reg;
        logic [X_W-1:0] cand;
        logic           take;

        assign cand = x_w[i-1] + (x_w[i-1] >> i);
        assign take = (cand <= TWO_X);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg <= '0;
            end
            else if (en)
            begin
                ctl_reg <= ctl_w[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg <= take ? cand : x_w[i-1];
                l_reg <= take ? (l_w[i-1] + LNF) : l_w[i-1];
            end
        end

        assign ctl_w[i] = ctl_reg;
        assign x_w[i]   = x_reg;
        assign l_w[i]   = l_reg;
    end

    // ln(2/x) is r/2 to well below an output step once r = 2 - x is small.
    assign resid = TWO_X - x_w[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_ctl_reg <= '0;
        end
        else if (en)
        begin
            fin_ctl_reg <= ctl_w[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_l_reg <= l_w[STAGES] + {1'b0, (resid >> 4)};
        end
    end

    assign ctl   = fin_ctl_reg;
    assign l_sum = fin_l_reg;

endmodule

### hdl/edts_div.sv
// ----------------------------------------------------------------------------
// edts_div
// Rounded division of the log sum by lambda * 2^18, one quotient bit per
// stage, with an up-front overflow check against a 31-bit quotient.
// ----------------------------------------------------------------------------
module edts_div
    import edts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  stage_ctl_t           in_ctl,
    input  logic [L_W-1:0]       in_l,
    input  logic [HAZARD_W-1:0]  hazard,
    output stage_ctl_t           ctl,
    output logic [QUOT_BITS-1:0] quot
);

    logic [D_W-1:0]       divisor;
    logic [N_W-1:0]       numer;
    logic                 over;

    stage_ctl_t           prep_ctl_reg;
    logic [N_W-1:0]       prep_rem_reg;

    stage_ctl_t           ctl_w  [QUOT_BITS+1];
    logic [N_W-1:0]       rem_w  [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] quot_w [QUOT_BITS+1];

    assign divisor = {hazard, {HAZARD_SHIFT{1'b0}}};
    assign numer   = {1'b0, in_l} + {{(N_W-D_W){1'b0}}, (divisor >> 1)};
    assign over    = in_ctl.flag || (hazard == '0) ||
                     ({{(CMP_W-N_W){1'b0}}, numer} >= {divisor, {QUOT_BITS{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_ctl_reg <= '0;
        end
        else if (en)
        begin
            prep_ctl_reg <= '{valid: in_ctl.valid, flag: over};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_rem_reg <= numer;
        end
    end

    assign ctl_w[0]  = prep_ctl_reg;
    assign rem_w[0]  = prep_rem_reg;
    assign quot_w[0] = '0;

    for (genvar st = 0; st < QUOT_BITS; st++)
    begin : g_bit
        localparam int SH = QUOT_BITS - 1 - st;
        stage_ctl_t           ctl_reg;
        logic [N_W-1:0]       rem_reg;
        logic [QUOT_BITS-1:0] quot_reg;
        logic [CMP_W-1:0]     dsh;
        logic [CMP_W-1:0]     rem_ext;
        logic [CMP_W-1:0]     diff;
        logic                 ge;

        assign dsh     = {{QUOT_BITS{1'b0}}, divisor} << SH;
        assign rem_ext = {{(CMP_W-N_W){1'b0}}, rem_w[st]};
        assign ge      = (rem_ext >= dsh);
        assign diff    = rem_ext - dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg <= '0;
            end
            else if (en)
            begin
                ctl_reg <= ctl_w[st];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= ge ? diff[N_W-1:0] : rem_w[st];
                quot_reg <= {quot_w[st][QUOT_BITS-2:0], ge};
            end
        end

        assign ctl_w[st+1]  = ctl_reg;
        assign rem_w[st+1]  = rem_reg;
        assign quot_w[st+1] = quot_reg;
    end

    assign ctl  = ctl_w[QUOT_BITS];
    assign quot = quot_w[QUOT_BITS];

endmodule
